[src/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Operation codes and controller/datapath interface types for the deque core.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    typedef struct packed {
        logic load;
        logic apply;
        logic scan_init;
        logic scan_step;
        logic finish;
    } deq_cmd_t;

    typedef struct packed {
        logic is_search;
        logic match;
        logic issue_done;
    } deq_sts_t;

endpackage

[src/deque_with_membership_search_core.sv]
// ----------------------------------------------------------------------------
// deque_with_membership_search_core
// Bounded double-ended queue of 32-bit values with membership search.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: op/value taken on a rising edge with start high and busy low.
//   Ops: push front, push back, pop front, pop back, search; other codes
//   leave the queue unchanged. Every beat returns one result beat.
//   Result beat: found/overflow/count valid for one cycle while done is high;
//   the receiver cannot stall it, so it must sample on that edge.
//   Push/pop beats pass through the EXEC state and then done_reg; busy drops
//   in the same cycle that done rises, so the next beat can be taken then.
//   A search reads the ring buffer one entry per cycle through its single
//   read port, and ends early on a match.
//   Reset clears the pointers and the occupancy, not the count output or
//   the storage. Entries are only read once written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module deque_with_membership_search_core
#(
    parameter int DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 op,
    input  logic signed [31:0]         value,
    output logic                       done,
    output logic                       found,
    output logic                       overflow,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import deq_pkg::*;

    deq_cmd_t cmd;
    deq_sts_t sts;

    deq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .op       (op),
        .value    (value),
        .done     (done),
        .found    (found),
        .overflow (overflow),
        .count    (count)
    );

endmodule

[src/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accepts a beat, runs the update or the entry-by-entry search.
// ----------------------------------------------------------------------------
module deq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output deq_pkg::deq_cmd_t cmd,
    input  deq_pkg::deq_sts_t sts
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_search)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (sts.match || sts.issue_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[src/deq_dp.sv]
// ----------------------------------------------------------------------------
// deq_dp
// Ring buffer storage, front/occupancy pointers, search compare, result regs.
// ----------------------------------------------------------------------------
module deq_dp
#(
    parameter int DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  deq_pkg::deq_cmd_t          cmd,
    output deq_pkg::deq_sts_t          sts,
    input  logic [2:0]                 op,
    input  logic signed [31:0]         value,
    output logic                       done,
    output logic                       found,
    output logic                       overflow,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW + 1)'(off);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    logic [31:0]   mem [DEPTH];

    logic [2:0]    op_reg;
    logic [31:0]   value_reg;
    logic [AW-1:0] front_reg;
    logic [AW-1:0] front_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          rd_vld_reg;
    logic          rd_vld_next;
    logic [31:0]   rd_data_reg;
    logic          done_reg;
    logic          found_reg;
    logic          overflow_reg;
    logic          overflow_next;
    logic [CW-1:0] count_reg;

    logic          full;
    logic          empty;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          issue;
    logic          match;

    assign full    = (occ_reg == FULL_C);
    assign empty   = (occ_reg == '0);
    assign rd_addr = wrap_add(front_reg, idx_reg);
    assign issue   = cmd.scan_step && (idx_reg != occ_reg);
    assign match   = rd_vld_reg && (rd_data_reg == value_reg);

    always_comb
    begin
        front_next    = front_reg;
        occ_next      = occ_reg;
        overflow_next = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = front_reg;
        if (cmd.apply)
        begin
            unique case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        front_next = (front_reg == '0) ? LAST_A : front_reg - 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = front_next;
                        occ_next   = occ_reg + ONE_C;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = wrap_add(front_reg, occ_reg);
                        occ_next = occ_reg + ONE_C;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        front_next = wrap_add(front_reg, ONE_C);
                        occ_next   = occ_reg - ONE_C;
                    end
                end
                OP_POP_BACK:
                begin
                    if (!empty)
                    begin
                        occ_next = occ_reg - ONE_C;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        idx_next    = idx_reg;
        rd_vld_next = 1'b0;
        if (cmd.scan_init)
        begin
            idx_next = '0;
        end
        else if (issue)
        begin
            idx_next    = idx_reg + ONE_C;
            rd_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (cmd.apply)
        begin
            found_reg    <= 1'b0;
            overflow_reg <= overflow_next;
            count_reg    <= occ_next;
        end
        else if (cmd.finish)
        begin
            found_reg    <= match;
            overflow_reg <= 1'b0;
            count_reg    <= occ_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            occ_reg    <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            occ_reg    <= occ_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= cmd.apply || cmd.finish;
        end
    end

    assign sts.is_search  = (op_reg == OP_SEARCH);
    assign sts.match      = match;
    assign sts.issue_done = (idx_reg == occ_reg);

    assign done     = done_reg;
    assign found    = found_reg;
    assign overflow = overflow_reg;
    assign count    = count_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_C)
        else $error("occupancy above depth");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result beat held longer than one cycle");

    a_found_search: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (op_reg == OP_SEARCH))
        else $error("found set on a non-search beat");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && overflow_reg) |-> (count_reg == FULL_C))
        else $error("overflow reported while not full");

endmodule
